[hw/rtl/ptb_pkg.sv]
package ptb_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int ALPHABET    = 26;
  localparam int NODE_CAP    = MAX_LEN + 2;
  localparam int NODE_W      = 13;
  localparam int LEN_W       = 14;
  localparam int CHAR_W      = 5;
  localparam int OCC_W       = 13;
  localparam int SCORE_W     = 25;
  localparam int POS_W       = 15;
  localparam int TEXT_AW     = $clog2(MAX_LEN);
  localparam int CHILD_DEPTH = NODE_CAP * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

  typedef struct packed {
    logic signed [LEN_W-1:0] len;
    logic [NODE_W-1:0]       step;
    logic [NODE_W-1:0]       depth;
    logic [NODE_W-1:0]       slink;
    logic [NODE_W-1:0]       series;
    logic [NODE_W-1:0]       parent;
    logic [CHAR_W-1:0]       letter;
  } node_t;

  localparam node_t ROOT_EMPTY = '{len: LEN_W'(0), step: '0, depth: '0,
                                   slink: NODE_W'(1), series: NODE_W'(1),
                                   parent: '0, letter: '0};
  localparam node_t ROOT_MINUS = '{len: -LEN_W'(1), step: '0, depth: '0,
                                   slink: NODE_W'(1), series: NODE_W'(1),
                                   parent: '0, letter: '0};

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE       = 5'd0;
  localparam op_t OP_ACCEPT     = 5'd1;
  localparam op_t OP_W_RDNODE   = 5'd2;
  localparam op_t OP_W_RDTEXT   = 5'd3;
  localparam op_t OP_W_RDLINK   = 5'd4;
  localparam op_t OP_W_RDTEXT2  = 5'd5;
  localparam op_t OP_W_TAKELINK = 5'd6;
  localparam op_t OP_W_TAKESER  = 5'd7;
  localparam op_t OP_RD_CHILD_U = 5'd8;
  localparam op_t OP_RD_CHILD_V = 5'd9;
  localparam op_t OP_CHK_CHILD  = 5'd10;
  localparam op_t OP_FOUND      = 5'd11;
  localparam op_t OP_OCC_INC    = 5'd12;
  localparam op_t OP_NEW        = 5'd13;
  localparam op_t OP_LINK       = 5'd14;
  localparam op_t OP_MAKE       = 5'd15;
  localparam op_t OP_OUT_RD     = 5'd16;
  localparam op_t OP_OUT_LATCH  = 5'd17;
  localparam op_t OP_P_INIT     = 5'd18;
  localparam op_t OP_P_RD       = 5'd19;
  localparam op_t OP_P_LINK     = 5'd20;
  localparam op_t OP_P_ADD      = 5'd21;
  localparam op_t OP_P_MAX      = 5'd22;
  localparam op_t OP_FIN        = 5'd23;

  typedef struct packed {
    logic full;
    logic last;
    logic match;
    logic child_ok;
    logic pass_done;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/ptb_ctrl.sv]
module ptb_ctrl import ptb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output op_t     op
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_W_NODE  = 5'd1;
  localparam logic [4:0] S_W_TEXT  = 5'd2;
  localparam logic [4:0] S_W_CHK   = 5'd3;
  localparam logic [4:0] S_W_LTEXT = 5'd4;
  localparam logic [4:0] S_W_LCHK  = 5'd5;
  localparam logic [4:0] S_W_DONE  = 5'd6;
  localparam logic [4:0] S_CH_CHK  = 5'd7;
  localparam logic [4:0] S_CH_VAL  = 5'd8;
  localparam logic [4:0] S_INC     = 5'd9;
  localparam logic [4:0] S_MAKE    = 5'd10;
  localparam logic [4:0] S_OUT_RD  = 5'd11;
  localparam logic [4:0] S_OUT_LAT = 5'd12;
  localparam logic [4:0] S_P_INIT  = 5'd13;
  localparam logic [4:0] S_P_TEST  = 5'd14;
  localparam logic [4:0] S_P_LINK  = 5'd15;
  localparam logic [4:0] S_P_ADD   = 5'd16;
  localparam logic [4:0] S_P_MAX   = 5'd17;
  localparam logic [4:0] S_FIN     = 5'd18;

  logic [4:0] state, state_next;
  logic       second, second_next;

  assign in_stall = (state != S_IDLE);

  // sequence the letter, the walks and the count pass
  always_comb begin
    state_next  = state;
    second_next = second;
    op          = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op          = OP_ACCEPT;
          second_next = 1'b0;
          state_next  = st.full ? S_OUT_RD : S_W_NODE;
        end
      end
      S_W_NODE: begin
        op         = OP_W_RDNODE;
        state_next = S_W_TEXT;
      end
      S_W_TEXT: begin
        op         = OP_W_RDTEXT;
        state_next = S_W_CHK;
      end
      S_W_CHK: begin
        if (st.match) begin
          state_next = S_W_DONE;
        end else begin
          op         = OP_W_RDLINK;
          state_next = S_W_LTEXT;
        end
      end
      S_W_LTEXT: begin
        op         = OP_W_RDTEXT2;
        state_next = S_W_LCHK;
      end
      S_W_LCHK: begin
        if (st.match) begin
          op         = OP_W_TAKELINK;
          state_next = S_W_DONE;
        end else begin
          op         = OP_W_TAKESER;
          state_next = S_W_NODE;
        end
      end
      S_W_DONE: begin
        op         = second ? OP_RD_CHILD_V : OP_RD_CHILD_U;
        state_next = S_CH_CHK;
      end
      S_CH_CHK: begin
        op         = OP_CHK_CHILD;
        state_next = S_CH_VAL;
      end
      S_CH_VAL: begin
        if (second) begin
          op         = OP_LINK;
          state_next = S_MAKE;
        end else if (st.child_ok) begin
          op         = OP_FOUND;
          state_next = S_INC;
        end else begin
          op          = OP_NEW;
          second_next = 1'b1;
          state_next  = S_W_NODE;
        end
      end
      S_INC: begin
        op         = OP_OCC_INC;
        state_next = S_OUT_RD;
      end
      S_MAKE: begin
        op         = OP_MAKE;
        state_next = S_OUT_RD;
      end
      S_OUT_RD: begin
        op         = OP_OUT_RD;
        state_next = S_OUT_LAT;
      end
      S_OUT_LAT: begin
        op         = OP_OUT_LATCH;
        state_next = st.last ? S_P_INIT : S_FIN;
      end
      S_P_INIT: begin
        op         = OP_P_INIT;
        state_next = S_P_TEST;
      end
      S_P_TEST: begin
        if (st.pass_done) begin
          state_next = S_FIN;
        end else begin
          op         = OP_P_RD;
          state_next = S_P_LINK;
        end
      end
      S_P_LINK: begin
        op         = OP_P_LINK;
        state_next = S_P_ADD;
      end
      S_P_ADD: begin
        op         = OP_P_ADD;
        state_next = S_P_MAX;
      end
      S_P_MAX: begin
        op         = OP_P_MAX;
        state_next = S_P_TEST;
      end
      S_FIN: begin
        if (st.out_free) begin
          op         = OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

endmodule

[hw/rtl/ptb_datapath.sv]
module ptb_datapath import ptb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  op_t                  op,
  output status_t              st,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic                 end_of_string,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [NODE_W-1:0]    node_index,
  output logic [NODE_W-1:0]    palindrome_length,
  output logic                 new_node,
  output logic [NODE_W-1:0]    suffix_palindrome_count,
  output logic [SCORE_W-1:0]   best_score,
  output logic                 score_valid,
  output logic                 overflow
);

  // memories; stale child entries are screened by fill count, parent and letter
  node_t             node_mem  [NODE_CAP];
  logic [OCC_W-1:0]  occ_mem   [NODE_CAP];
  logic [CHAR_W-1:0] text_mem  [MAX_LEN];
  bit   [NODE_W-1:0] child_mem [CHILD_DEPTH];

  // control state
  logic [NODE_W-1:0] pos, nodes_used, cur;
  // payload registers
  logic [CHAR_W-1:0] ch_q;
  logic              last_q, dropped_q, created_q;
  logic [NODE_W-1:0] w, w_link, w_ser, cand_link;
  logic signed [LEN_W-1:0] w_len, cand_len, u_len;
  logic [NODE_W-1:0] u, u_link, owner, c_q, lk_q, nw;
  logic              c_range_q;
  logic [NODE_W-1:0] i_q, lk_p, len_n;
  logic [OCC_W-1:0]  occ_n;
  logic [SCORE_W-1:0] prod_q, best;
  logic [NODE_W-1:0] res_len, res_depth;

  // read data
  node_t             node_q, nd;
  logic              rd_root, rd_one;
  logic [OCC_W-1:0]  occ_q;
  logic [CHAR_W-1:0] text_q;
  logic              p_ok_q;
  logic [NODE_W-1:0] child_q;

  // read and write controls
  logic              node_re, node_we, occ_re, occ_we, text_re;
  logic [NODE_W-1:0] node_raddr, occ_raddr, occ_waddr;
  logic [OCC_W-1:0]  occ_wdata;
  node_t             node_wdata;
  logic signed [POS_W-1:0] p;
  logic [CHAR_W-1:0] ch_sat;
  logic [CHILD_AW-1:0] child_raddr, child_waddr;
  logic signed [LEN_W-1:0] new_len;
  logic [NODE_W-1:0] new_step, n_idx;
  logic [2*OCC_W-1:0] prod_full;

  function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] n,
                                                      input logic [CHAR_W-1:0] c);
    child_addr = CHILD_AW'(n) * CHILD_AW'(ALPHABET) + CHILD_AW'(c);
  endfunction

  assign ch_sat = (char_code >= CHAR_W'(ALPHABET)) ? CHAR_W'(ALPHABET - 1) : char_code;
  assign nd     = rd_root ? (rd_one ? ROOT_MINUS : ROOT_EMPTY) : node_q;
  assign n_idx  = i_q - NODE_W'(1);

  // mirror position: pos - len - 1, taken from the node just read
  assign p = $signed({2'b00, pos}) - POS_W'(nd.len) - POS_W'(1);

  assign child_raddr = child_addr(w, ch_q);
  assign child_waddr = child_addr(u, ch_q);

  assign new_len  = u_len + LEN_W'(2);
  assign new_step = NODE_W'(new_len - nd.len);
  assign prod_full = occ_n * len_n;

  // status back to the controller
  assign st.full      = (pos >= NODE_W'(MAX_LEN));
  assign st.last      = last_q;
  assign st.match     = p_ok_q && (text_q == ch_q);
  assign st.child_ok  = c_range_q && (nd.parent == owner) && (nd.letter == ch_q);
  assign st.pass_done = (i_q <= NODE_W'(2));
  assign st.out_free  = !out_valid || !out_stall;

  // select node and occurrence ports
  always_comb begin
    node_re    = 1'b0;
    node_raddr = w;
    occ_re     = 1'b0;
    occ_raddr  = c_q;
    occ_we     = 1'b0;
    occ_waddr  = cur;
    occ_wdata  = occ_q + OCC_W'(1);
    text_re    = 1'b0;
    node_we    = (op == OP_MAKE);
    node_wdata = '{len: new_len, step: new_step, depth: nd.depth + NODE_W'(1),
                   slink: lk_q,
                   series: (new_step == nd.step) ? nd.series : lk_q,
                   parent: u, letter: ch_q};
    case (op)
      OP_W_RDNODE: begin
        node_re = 1'b1;
      end
      OP_W_RDTEXT, OP_W_RDTEXT2: begin
        text_re = 1'b1;
      end
      OP_W_RDLINK: begin
        node_re    = 1'b1;
        node_raddr = w_link;
      end
      OP_CHK_CHILD: begin
        node_re    = 1'b1;
        node_raddr = child_q;
      end
      OP_LINK: begin
        node_re    = 1'b1;
        node_raddr = st.child_ok ? c_q : '0;
      end
      OP_OUT_RD: begin
        node_re    = 1'b1;
        node_raddr = cur;
      end
      OP_P_RD: begin
        node_re    = 1'b1;
        node_raddr = n_idx;
        occ_re     = 1'b1;
        occ_raddr  = n_idx;
      end
      OP_P_LINK: begin
        occ_re    = 1'b1;
        occ_raddr = nd.slink;
      end
      OP_FOUND: begin
        occ_re = 1'b1;
      end
      OP_OCC_INC: begin
        occ_we = 1'b1;
      end
      OP_MAKE: begin
        occ_we    = 1'b1;
        occ_waddr = nw;
        occ_wdata = OCC_W'(1);
      end
      OP_P_ADD: begin
        occ_we    = 1'b1;
        occ_waddr = lk_p;
        occ_wdata = occ_q + occ_n;
      end
      default: begin
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[nw] <= node_wdata;
    end
    if (node_re) begin
      node_q  <= node_mem[node_raddr];
      rd_root <= (node_raddr < NODE_W'(2));
      rd_one  <= node_raddr[0];
    end
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (occ_re) begin
      occ_q <= occ_mem[occ_raddr];
    end
    if (op == OP_ACCEPT && !st.full) begin
      text_mem[pos[TEXT_AW-1:0]] <= ch_sat;
    end
    if (text_re) begin
      text_q <= text_mem[TEXT_AW'(p - POS_W'(1))];
      p_ok_q <= (p >= POS_W'(1));
    end
    if (op == OP_MAKE) begin
      child_mem[child_waddr] <= nw;
    end
    if (op == OP_RD_CHILD_U || op == OP_RD_CHILD_V) begin
      child_q <= child_mem[child_raddr];
    end
  end

  // hold the tree counters and the current suffix
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      nodes_used <= NODE_W'(2);
      cur        <= NODE_W'(1);
    end else begin
      case (op)
        OP_ACCEPT: begin
          if (!st.full) begin
            pos <= pos + NODE_W'(1);
          end
        end
        OP_FOUND: begin
          cur <= c_q;
        end
        OP_MAKE: begin
          cur        <= nw;
          nodes_used <= nodes_used + NODE_W'(1);
        end
        OP_FIN: begin
          if (last_q) begin
            pos        <= '0;
            nodes_used <= NODE_W'(2);
            cur        <= NODE_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // walk registers, new node fields and count pass
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        ch_q      <= ch_sat;
        last_q    <= end_of_string;
        dropped_q <= st.full;
        created_q <= 1'b0;
        best      <= '0;
        w         <= cur;
      end
      OP_W_RDTEXT: begin
        w_len  <= nd.len;
        w_link <= nd.slink;
        w_ser  <= nd.series;
      end
      OP_W_RDTEXT2: begin
        cand_len  <= nd.len;
        cand_link <= nd.slink;
      end
      OP_W_TAKELINK: begin
        w      <= w_link;
        w_len  <= cand_len;
        w_link <= cand_link;
      end
      OP_W_TAKESER: begin
        w <= w_ser;
      end
      OP_RD_CHILD_U: begin
        u      <= w;
        u_len  <= w_len;
        u_link <= w_link;
        owner  <= w;
      end
      OP_RD_CHILD_V: begin
        owner <= w;
      end
      OP_CHK_CHILD: begin
        c_q       <= child_q;
        c_range_q <= (child_q >= NODE_W'(2)) && (child_q < nodes_used);
      end
      OP_NEW: begin
        nw <= nodes_used;
        w  <= u_link;
      end
      OP_LINK: begin
        lk_q <= st.child_ok ? c_q : '0;
      end
      OP_MAKE: begin
        created_q <= 1'b1;
      end
      OP_OUT_LATCH: begin
        res_len   <= (nd.len < 0) ? '0 : nd.len[NODE_W-1:0];
        res_depth <= nd.depth;
      end
      OP_P_INIT: begin
        i_q  <= nodes_used;
        best <= '0;
      end
      OP_P_LINK: begin
        lk_p  <= nd.slink;
        len_n <= nd.len[NODE_W-1:0];
        occ_n <= occ_q;
      end
      OP_P_ADD: begin
        prod_q <= prod_full[SCORE_W-1:0];
      end
      OP_P_MAX: begin
        if (prod_q > best) begin
          best <= prod_q;
        end
        i_q <= i_q - NODE_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_FIN) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_FIN) begin
      node_index              <= cur;
      palindrome_length       <= res_len;
      new_node                <= created_q;
      suffix_palindrome_count <= res_depth;
      best_score              <= best;
      score_valid             <= last_q;
      overflow                <= dropped_q;
    end
  end

  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= pos + NODE_W'(2))
    else $error("more nodes than letters allow");

  a_cur_bound: assert property (@(posedge clk) disable iff (rst)
    cur < nodes_used)
    else $error("current suffix node beyond fill count");

  a_found_real: assert property (@(posedge clk) disable iff (rst)
    (op == OP_FOUND) |-> (c_q >= NODE_W'(2)))
    else $error("root taken as existing child");

endmodule

[hw/rtl/palindromic_tree_builder.sv]
// channel  | handshake          | beat fields
// ---------+--------------------+-----------------------------------------------
// input    | in_valid/in_stall  | char_code, end_of_string
// output   | out_valid/out_stall| node_index, palindrome_length, new_node,
//          |                    | suffix_palindrome_count, best_score,
//          |                    | score_valid, overflow
//
// A letter runs the mirror test of its fail walk; a suffix link that is taken and
// each series step of that walk add to its time, and a new node adds a second
// walk of the same form. A dropped letter skips the walks. End of string adds a
// count pass over each node created. The single node memory read port sets the
// pace of these steps.
// Reset (rst, synchronous) empties the tree at once; no clearing pass is needed.
// A stalled result waits in the output register while the next letter is taken.
module palindromic_tree_builder import ptb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               end_of_string,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [NODE_W-1:0]  node_index,
  output logic [NODE_W-1:0]  palindrome_length,
  output logic               new_node,
  output logic [NODE_W-1:0]  suffix_palindrome_count,
  output logic [SCORE_W-1:0] best_score,
  output logic               score_valid,
  output logic               overflow
);

  status_t st;
  op_t     op;

  // sequence each letter
  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  // tree memories and arithmetic
  ptb_datapath u_dp (
    .clk                     (clk),
    .rst                     (rst),
    .op                      (op),
    .st                      (st),
    .char_code               (char_code),
    .end_of_string           (end_of_string),
    .out_stall               (out_stall),
    .out_valid               (out_valid),
    .node_index              (node_index),
    .palindrome_length       (palindrome_length),
    .new_node                (new_node),
    .suffix_palindrome_count (suffix_palindrome_count),
    .best_score              (best_score),
    .score_valid             (score_valid),
    .overflow                (overflow)
  );

endmodule
